[rtl/dlcba_pkg.sv]
// Shared widths, register indexes, reset values and lane control type for the block averager.
package dlcba_pkg;

    localparam int READ_W    = 24;
    localparam int OFS_W     = 25;
    localparam int DIFF_W    = 26;
    localparam int SUM_W     = 32;
    localparam int WEIGHT_W  = 26;
    localparam int THR_W     = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_A       = 3'd0,
        CFG_OFFSET_B_WRAP  = 3'd1,
        CFG_OFFSET_B_PLAIN = 3'd2,
        CFG_WRAP_THR       = 3'd3,
        CFG_RISE_THR       = 3'd4
    } t_cfg_idx;

    localparam logic signed [OFS_W-1:0] RST_OFFSET_A       = 25'sd13128;
    localparam logic signed [OFS_W-1:0] RST_OFFSET_B_WRAP  = 25'sd16764472;
    localparam logic signed [OFS_W-1:0] RST_OFFSET_B_PLAIN = -25'sd12744;
    localparam logic [READ_W-1:0]       RST_WRAP_THR       = 24'd16700000;
    localparam logic [THR_W-1:0]        RST_RISE_THR       = 25'd409600;

    typedef struct packed {
        logic acc_en;
        logic last;
        logic ld2;
        logic ld3;
    } t_lane_ctl;

endpackage

[rtl/dlcba_in_if.sv]
// Input channel carrying one pair of raw load cell readings.
interface dlcba_in_if;
    import dlcba_pkg::*;

    logic              valid;
    logic              ready;
    logic [READ_W-1:0] reading_a;
    logic [READ_W-1:0] reading_b;

    modport source (output valid, output reading_a, output reading_b, input ready);
    modport sink   (input valid, input reading_a, input reading_b, output ready);
endinterface

[rtl/dlcba_out_if.sv]
// Output channel carrying one block weight and its rise flag.
interface dlcba_out_if;
    import dlcba_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [WEIGHT_W-1:0] weight_counts;
    logic                       weight_rose;

    modport source (output valid, output weight_counts, output weight_rose, input ready);
    modport sink   (input valid, input weight_counts, input weight_rose, output ready);
endinterface

[rtl/dlcba_lane.sv]
// One cell lane: offset removal, block accumulation and truncating divide by the block size.
module dlcba_lane
    import dlcba_pkg::*;
#(
    parameter int PAIRS_PER_BLOCK = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [READ_W-1:0]       i_reading,
    input  logic signed [OFS_W-1:0] i_offset,
    input  t_lane_ctl               i_ctl,
    output logic signed [SUM_W-1:0] o_quot
);

    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(PAIRS_PER_BLOCK);
    localparam logic [SUM_W-1:0] RECIP   = SUM_W'(64'hFFFF_FFFF / PAIRS_PER_BLOCK);

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  total;

    logic                     r_neg1;
    logic [SUM_W-1:0]         r_mag1;
    logic                     r_neg2;
    logic [SUM_W-1:0]         r_mag2;
    logic [SUM_W-1:0]         r_q2;
    logic signed [SUM_W-1:0]  r_quot3;

    logic [2*SUM_W-1:0]       prod;
    logic [SUM_W-1:0]         rem;
    logic [SUM_W-1:0]         q_fix;

    assign diff  = $signed({2'b00, i_reading}) - $signed({i_offset[OFS_W-1], i_offset});
    assign total = r_sum + $signed({{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff});

    assign prod  = {{SUM_W{1'b0}}, r_mag1} * {{SUM_W{1'b0}}, RECIP};
    assign rem   = r_mag2 - r_q2 * DIVISOR;
    assign q_fix = (rem >= DIVISOR) ? r_q2 + SUM_W'(1) : r_q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.acc_en) begin
            r_sum <= i_ctl.last ? '0 : total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en && i_ctl.last) begin
            r_neg1 <= total[SUM_W-1];
            r_mag1 <= total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
        end
        if (i_ctl.ld2) begin
            r_neg2 <= r_neg1;
            r_mag2 <= r_mag1;
            r_q2   <= prod[2*SUM_W-1:SUM_W];
        end
        if (i_ctl.ld3) begin
            r_quot3 <= r_neg2 ? -$signed(q_fix) : $signed(q_fix);
        end
    end

    assign o_quot = r_quot3;

endmodule

[rtl/dlcba_merge.sv]
// Merge stage: combine lane averages, saturate, detect a rise and hold the previous weight.
module dlcba_merge
    import dlcba_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ld,
    input  logic signed [SUM_W-1:0]    i_quot_a,
    input  logic signed [SUM_W-1:0]    i_quot_b,
    input  logic [THR_W-1:0]           i_rise_thr,
    output logic signed [WEIGHT_W-1:0] o_weight,
    output logic                       o_rose
);

    localparam int COMB_W = SUM_W + 2;
    localparam int CMP_W  = WEIGHT_W + 1;
    localparam logic signed [COMB_W-1:0] W_MAX = 34'sd33554431;
    localparam logic signed [COMB_W-1:0] W_MIN = -34'sd33554432;

    logic signed [WEIGHT_W-1:0] r_prev;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic                       r_rose;

    logic signed [COMB_W-1:0]   comb;
    logic signed [WEIGHT_W-1:0] sat;
    logic signed [CMP_W-1:0]    limit;
    logic                       rose;

    always_comb begin
        comb = $signed({{2{i_quot_b[SUM_W-1]}}, i_quot_b})
             - $signed({{2{i_quot_a[SUM_W-1]}}, i_quot_a});
        if (comb > W_MAX) begin
            sat = W_MAX[WEIGHT_W-1:0];
        end else if (comb < W_MIN) begin
            sat = W_MIN[WEIGHT_W-1:0];
        end else begin
            sat = comb[WEIGHT_W-1:0];
        end
        limit = $signed({r_prev[WEIGHT_W-1], r_prev}) + $signed({2'b00, i_rise_thr});
        rose  = $signed({sat[WEIGHT_W-1], sat}) > limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_ld) begin
            r_prev <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_weight <= sat;
            r_rose   <= rose;
        end
    end

    assign o_weight = r_weight;
    assign o_rose   = r_rose;

endmodule

[rtl/dual_load_cell_block_averager.sv]
// Top level of the dual load cell block averager.
//
// Input channel i_in carries one pair of raw 24-bit readings per item; output
// channel o_out carries one weight in counts (2^23 counts = 0.512 kg) and a
// rise flag at the end of every block of PAIRS_PER_BLOCK pairs.
// Configuration is a plain write port: i_cfg_we, i_cfg_index, i_cfg_data.
// Throughput: one pair per cycle while i_in.ready is high. The two cell
// lanes accumulate side by side in the cycle an item is accepted; non-final
// pairs never wait on the output. The result of a block is registered in
// turn: sign/magnitude loads on the accepting edge, then reciprocal
// multiply, correction, merge register.
// The 32x32 reciprocal multiply in each lane sets the stage depth.
// When the receiver stalls, the result waits in the output register and the
// divide stages fill; a final pair is held off only when all stages are full.
// Reset clears sums, pair count, previous weight and pipeline valids, and
// loads the register reset values.
module dual_load_cell_block_averager
    import dlcba_pkg::*;
#(
    parameter int PAIRS_PER_BLOCK = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    dlcba_in_if.sink             i_in,
    dlcba_out_if.source          o_out
);

    localparam int CNT_W = (PAIRS_PER_BLOCK > 1) ? $clog2(PAIRS_PER_BLOCK) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAIRS_PER_BLOCK - 1);

    logic signed [OFS_W-1:0] r_ofs_a;
    logic signed [OFS_W-1:0] r_ofs_b_wrap;
    logic signed [OFS_W-1:0] r_ofs_b_plain;
    logic [READ_W-1:0]       r_wrap_thr;
    logic [THR_W-1:0]        r_rise_thr;

    logic [CNT_W-1:0]        r_count;
    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic                    r_vo;

    logic                    last;
    logic                    accept;
    logic                    rdy_out;
    logic                    rdy3;
    logic                    rdy2;
    logic                    rdy1;
    logic                    ld_out;
    t_lane_ctl               lane_ctl;
    logic signed [OFS_W-1:0] ofs_b;
    logic signed [SUM_W-1:0] quot_a;
    logic signed [SUM_W-1:0] quot_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_a       <= RST_OFFSET_A;
            r_ofs_b_wrap  <= RST_OFFSET_B_WRAP;
            r_ofs_b_plain <= RST_OFFSET_B_PLAIN;
            r_wrap_thr    <= RST_WRAP_THR;
            r_rise_thr    <= RST_RISE_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET_A:       r_ofs_a       <= $signed(i_cfg_data);
                CFG_OFFSET_B_WRAP:  r_ofs_b_wrap  <= $signed(i_cfg_data);
                CFG_OFFSET_B_PLAIN: r_ofs_b_plain <= $signed(i_cfg_data);
                CFG_WRAP_THR:       r_wrap_thr    <= i_cfg_data[READ_W-1:0];
                CFG_RISE_THR:       r_rise_thr    <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign last    = (r_count == LAST_CNT);
    assign rdy_out = !r_vo || o_out.ready;
    assign rdy3    = !r_v3 || rdy_out;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign i_in.ready = !last || rdy1;
    assign accept  = i_in.valid && i_in.ready;
    assign ld_out  = rdy_out && r_v3;

    assign lane_ctl.acc_en = accept;
    assign lane_ctl.last   = last;
    assign lane_ctl.ld2    = rdy2 && r_v1;
    assign lane_ctl.ld3    = rdy3 && r_v2;

    assign ofs_b = (i_in.reading_b > r_wrap_thr) ? r_ofs_b_wrap : r_ofs_b_plain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_vo    <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= last ? '0 : r_count + CNT_W'(1);
            end
            if (rdy1) begin
                r_v1 <= accept && last;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy_out) begin
                r_vo <= r_v3;
            end
        end
    end

    dlcba_lane #(
        .PAIRS_PER_BLOCK(PAIRS_PER_BLOCK)
    ) u_lane_a (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reading (i_in.reading_a),
        .i_offset  (r_ofs_a),
        .i_ctl     (lane_ctl),
        .o_quot    (quot_a)
    );

    dlcba_lane #(
        .PAIRS_PER_BLOCK(PAIRS_PER_BLOCK)
    ) u_lane_b (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reading (i_in.reading_b),
        .i_offset  (ofs_b),
        .i_ctl     (lane_ctl),
        .o_quot    (quot_b)
    );

    dlcba_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld       (ld_out),
        .i_quot_a   (quot_a),
        .i_quot_b   (quot_b),
        .i_rise_thr (r_rise_thr),
        .o_weight   (o_out.weight_counts),
        .o_rose     (o_out.weight_rose)
    );

    assign o_out.valid = r_vo;

endmodule

[tb/dual_load_cell_block_averager_tb.sv]
// Testbench for the dual load cell block averager: directed table plus random pairs.
module dual_load_cell_block_averager_tb;
    import dlcba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     N_PAIRS       = 25;
    localparam int     LATENCY       = 4;
    localparam int     SETTLE        = LATENCY + 4;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     RANDOM_PAIRS  = 375;
    localparam int     MAX_RUN       = 130;
    localparam longint W_MAX         = (longint'(1) << (WEIGHT_W - 1)) - 1;
    localparam longint W_MIN         = -(longint'(1) << (WEIGHT_W - 1));

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(CFG_RISE_THR + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

    typedef struct {
        logic signed [WEIGHT_W-1:0] weight;
        logic                       rose;
    } block_weight_t;

    typedef enum {ROW_PAIR, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DAT_W-1:0]       data;
        logic [READ_W-1:0]          a;
        logic [READ_W-1:0]          b;
        int                         reps;
        bit                         typed;
        logic signed [WEIGHT_W-1:0] w;
        logic                       rose;
    } plan_row_t;

    localparam int N_ROWS = 27;

    plan_row_t plan [N_ROWS] = '{
        '{ROW_PAIR, CFG_OFFSET_A, 0, 13128, 0, 25, 1, 12744, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 0, 16777215, 25, 1, 25871, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 0, 16700000, 25, 1, 16725872, 1},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 16777215, 16700001, 12, 0, 0, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 1, 16700000, 13, 0, 0, 0},
        '{ROW_CFG, CFG_OFFSET_A, 25'h0FFFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_WRAP_THR, 25'h1FFFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_OFFSET_B_PLAIN, 25'h1000000, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RISE_THR, 25'h0000000, 0, 0, 0, 0, 0, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 0, 16777215, 25, 1, 33554431, 1},
        '{ROW_CFG, CFG_OFFSET_A, 25'h1000000, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_WRAP_THR, 25'h0000000, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_OFFSET_B_WRAP, 25'h0FFFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RISE_THR, 25'h1FFFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 16777215, 1, 25, 1, -33554432, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 0, 0, 25, 1, 0, 1},
        '{ROW_CFG, CFG_IDX_SPARE_LO, 25'h0000000, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_IDX_SPARE_HI, 25'h1FFFFFF, 0, 0, 0, 0, 0, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 0, 0, 25, 1, 0, 0},
        '{ROW_CFG, CFG_OFFSET_A, RST_OFFSET_A, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_OFFSET_B_WRAP, RST_OFFSET_B_WRAP, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_OFFSET_B_PLAIN, RST_OFFSET_B_PLAIN, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_WRAP_THR, CFG_DAT_W'(RST_WRAP_THR), 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_RISE_THR, RST_RISE_THR, 0, 0, 0, 0, 0, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 5000, 16750000, 10, 0, 0, 0},
        '{ROW_CFG, CFG_WRAP_THR, 16760000, 0, 0, 0, 0, 0, 0},
        '{ROW_PAIR, CFG_OFFSET_A, 0, 5000, 16750000, 15, 0, 0, 0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    dlcba_in_if  in_ch ();
    dlcba_out_if out_ch ();

    dual_load_cell_block_averager #(
        .PAIRS_PER_BLOCK(N_PAIRS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic signed [OFS_W-1:0]    ofs_a       = RST_OFFSET_A;
    logic signed [OFS_W-1:0]    ofs_b_wrap  = RST_OFFSET_B_WRAP;
    logic signed [OFS_W-1:0]    ofs_b_plain = RST_OFFSET_B_PLAIN;
    logic [READ_W-1:0]          wrap_thr    = RST_WRAP_THR;
    logic [THR_W-1:0]           rise_thr    = RST_RISE_THR;
    logic signed [SUM_W-1:0]    sum_a       = '0;
    logic signed [SUM_W-1:0]    sum_b       = '0;
    int                         pair_cnt    = 0;
    logic signed [WEIGHT_W-1:0] prev_w      = '0;

    block_weight_t weights_due [$];
    int            mismatches    = 0;
    bit            rx_hold_req   = 1'b0;
    bit            hold_run      = 1'b0;
    bit            quiet_tail    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("[dual_load_cell_block_averager] ERROR");
        $finish;
    end

    function automatic bit fold_pair(input logic [READ_W-1:0] a, input logic [READ_W-1:0] b,
                                     output logic signed [WEIGHT_W-1:0] w, output logic rose);
        longint avg_sum;
        w    = '0;
        rose = 1'b0;
        sum_a = sum_a + SUM_W'(longint'(a) - longint'(ofs_a));
        if (b > wrap_thr) begin
            sum_b = sum_b + SUM_W'(longint'(b) - longint'(ofs_b_wrap));
        end else begin
            sum_b = sum_b + SUM_W'(longint'(b) - longint'(ofs_b_plain));
        end
        pair_cnt++;
        if (pair_cnt != N_PAIRS) return 1'b0;
        avg_sum = -(longint'(sum_a) / N_PAIRS) + longint'(sum_b) / N_PAIRS;
        if (avg_sum > W_MAX) avg_sum = W_MAX;
        else if (avg_sum < W_MIN) avg_sum = W_MIN;
        rose     = avg_sum > longint'(prev_w) + longint'(rise_thr);
        w        = WEIGHT_W'(avg_sum);
        prev_w   = w;
        sum_a    = '0;
        sum_b    = '0;
        pair_cnt = 0;
        return 1'b1;
    endfunction

    task automatic send_pair(input logic [READ_W-1:0] a, input logic [READ_W-1:0] b,
                             input bit typed, input logic signed [WEIGHT_W-1:0] tw,
                             input logic tr);
        block_weight_t              due;
        logic signed [WEIGHT_W-1:0] w;
        logic                       r;
        in_ch.valid     <= 1'b1;
        in_ch.reading_a <= a;
        in_ch.reading_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        if (fold_pair(a, b, w, r)) begin
            due.weight = typed ? tw : w;
            due.rose   = typed ? tr : r;
            weights_due.push_back(due);
        end
        if (!hold_run && !quiet_tail && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (weights_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_OFFSET_A:       ofs_a       = val[OFS_W-1:0];
            CFG_OFFSET_B_WRAP:  ofs_b_wrap  = val[OFS_W-1:0];
            CFG_OFFSET_B_PLAIN: ofs_b_plain = val[OFS_W-1:0];
            CFG_WRAP_THR:       wrap_thr    = val[READ_W-1:0];
            CFG_RISE_THR:       rise_thr    = val[THR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request, none in the tail
    initial begin
        forever begin
            if (rx_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : check_weights
        block_weight_t due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (weights_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item, weight_counts %0d weight_rose %0d",
                         $time, out_ch.weight_counts, out_ch.weight_rose);
            end else begin
                due = weights_due.pop_front();
                if (out_ch.weight_counts !== due.weight) begin
                    mismatches++;
                    $display("%0t: weight_counts expected %0d, got %0d",
                             $time, due.weight, out_ch.weight_counts);
                end
                if (out_ch.weight_rose !== due.rose) begin
                    mismatches++;
                    $display("%0t: weight_rose expected %0d, got %0d",
                             $time, due.rose, out_ch.weight_rose);
                end
            end
        end
    end

    initial begin
        int                   random_pairs;
        int                   phase;
        int                   run_len;
        int                   n_writes;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] val;
        logic [READ_W-1:0]    base_a;
        logic [READ_W-1:0]    base_b;
        logic [READ_W-1:0]    a;
        logic [READ_W-1:0]    b;

        random_pairs    = 0;
        phase           = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_OFFSET_A;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.reading_a <= '0;
        in_ch.reading_b <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            if (plan[r].kind == ROW_CFG) begin
                drain();
                cfg_write(plan[r].idx, plan[r].data);
            end else begin
                for (int k = 0; k < plan[r].reps; k++) begin
                    send_pair(plan[r].a, plan[r].b, plan[r].typed && k == plan[r].reps - 1,
                              plan[r].w, plan[r].rose);
                end
            end
        end

        while (random_pairs < RANDOM_PAIRS) begin
            drain();
            n_writes = $urandom_range(0, 4);
            for (int k = 0; k < n_writes; k++) begin
                idx = CFG_IDX_W'($urandom_range(0, 2 ** CFG_IDX_W - 1));
                case ($urandom_range(0, 5))
                    0: val = '0;
                    1: val = '1;
                    2: val = {1'b1, {(CFG_DAT_W - 1){1'b0}}};
                    3: val = {1'b0, {(CFG_DAT_W - 1){1'b1}}};
                    4: begin
                        case (idx)
                            CFG_OFFSET_A:       val = RST_OFFSET_A;
                            CFG_OFFSET_B_WRAP:  val = RST_OFFSET_B_WRAP;
                            CFG_OFFSET_B_PLAIN: val = RST_OFFSET_B_PLAIN;
                            CFG_WRAP_THR:       val = CFG_DAT_W'(RST_WRAP_THR);
                            CFG_RISE_THR:       val = RST_RISE_THR;
                            default:            val = CFG_DAT_W'($urandom);
                        endcase
                    end
                    default: begin
                        val = (idx == CFG_RISE_THR) ? CFG_DAT_W'($urandom_range(0, 1 << 21))
                                                    : CFG_DAT_W'($urandom);
                    end
                endcase
                cfg_write(idx, val);
            end

            quiet_tail = random_pairs + MAX_RUN >= RANDOM_PAIRS;
            hold_run   = phase == 2;
            rx_hold_req = hold_run;
            run_len    = hold_run ? 220 : $urandom_range(30, MAX_RUN);
            base_a     = ofs_a[READ_W-1:0] + READ_W'($urandom_range(0, 600000));
            base_b     = wrap_thr - READ_W'(300000) + READ_W'($urandom_range(0, 600000));

            for (int k = 0; k < run_len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        a = READ_W'($urandom);
                        b = READ_W'($urandom);
                    end
                    2: begin
                        a = $urandom_range(0, 1) ? '1 : '0;
                        b = $urandom_range(0, 1) ? '1 : '0;
                    end
                    3: begin
                        a = base_a + READ_W'($urandom_range(0, 8191));
                        b = wrap_thr + READ_W'($urandom_range(0, 2)) - READ_W'(1);
                    end
                    default: begin
                        a = base_a + READ_W'($urandom_range(0, 8191));
                        b = base_b + READ_W'($urandom_range(0, 8191)) - READ_W'(4096);
                    end
                endcase
                if ($urandom_range(0, 39) == 0) begin
                    base_a = base_a - READ_W'($urandom_range(0, 400000));
                    base_b = base_b + READ_W'($urandom_range(0, 400000));
                end
                send_pair(a, b, 1'b0, '0, 1'b0);
                random_pairs++;
            end
            hold_run = 1'b0;
            phase++;
        end

        drain();
        if (mismatches == 0) begin
            $display("[dual_load_cell_block_averager] OK");
        end else begin
            $display("[dual_load_cell_block_averager] ERROR");
        end
        $finish;
    end

endmodule
